### hdl/ubh_pkg.sv
// Shared types and constants for the uniform-bin histogram.
// Used by ubh_front, ubh_queue, ubh_back and uniform_bin_histogram.
package ubh_pkg;

  localparam int DATA_W      = 32;
  localparam int BIN_NUM_W   = 8;
  localparam int NUM_BINS_W  = 9;
  localparam int CFG_INDEX_W = 2;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QLEVEL_W    = 3;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEFT_EDGE  = 2'd0,
    REG_RIGHT_EDGE = 2'd1,
    REG_BIN_SCALE  = 2'd2,
    REG_NUM_BINS   = 2'd3
  } reg_index_t;

  // Register reset values
  localparam logic signed [DATA_W-1:0] LEFT_EDGE_RST  = 32'sh0000_0000;
  localparam logic signed [DATA_W-1:0] RIGHT_EDGE_RST = 32'sh0100_0000;
  localparam logic [DATA_W-1:0]        BIN_SCALE_RST  = 32'h0001_0000;
  localparam logic [NUM_BINS_W-1:0]    NUM_BINS_RST   = 9'd256;

  // Item function codes
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [DATA_W-1:0] sample;
    logic [BIN_NUM_W-1:0]     bin_select;
  } item_t;

  typedef struct packed {
    logic [BIN_NUM_W-1:0] bin_number;
    logic [DATA_W-1:0]    bin_count;
    logic                 in_range;
  } result_t;

  // Classified operation handed to the back end
  typedef enum logic [1:0] {
    JOB_CLEAR = 2'd0,
    JOB_ADD   = 2'd1,
    JOB_READ  = 2'd2,
    JOB_NONE  = 2'd3
  } job_op_t;

  // Bin index is wide enough for every bin that num_bins can select
  typedef struct packed {
    job_op_t               op;
    logic [NUM_BINS_W-1:0] bin;
    logic                  hit;
  } job_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

### hdl/ubh_front.sv
// Front end: configuration registers, item acceptance, range check and
// bin computation. Depends on ubh_pkg.
module ubh_front
  import ubh_pkg::*;
#(
  parameter int BINS = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  item_t                  item,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]      cfg_data,
  input  logic [QLEVEL_W-1:0]    level,
  input  back_status_t           status,
  output logic                   push,
  output job_t                   job
);

  // num_bins cannot exceed 511, so that bounds the bins in use as well as BINS
  localparam int NB_MAX = (BINS > 511) ? 511 : BINS;
  localparam logic [NUM_BINS_W-1:0] LAST_MAX = NUM_BINS_W'(NB_MAX - 1);
  localparam int SUM_W = QLEVEL_W + 1;

  logic signed [DATA_W-1:0] left_edge;
  logic signed [DATA_W-1:0] right_edge;
  logic [DATA_W-1:0]        bin_scale;
  logic [NUM_BINS_W-1:0]    num_bins;

  logic                 accept;
  logic                 in_range;
  logic                 known;
  job_op_t              op_in;
  logic [DATA_W-1:0]    diff_in;
  logic                 hit_in;

  // Stage 1: classified item
  logic                 v1;
  job_op_t              op1;
  logic [DATA_W-1:0]    diff1;
  logic [BIN_NUM_W-1:0] sel1;
  logic                 hit1;

  // Stage 2: product integer part
  logic                 v2;
  job_op_t              op2;
  logic [DATA_W-1:0]    hi2;
  logic [BIN_NUM_W-1:0] sel2;
  logic                 hit2;

  logic [2*DATA_W-1:0]   prod;
  logic [NUM_BINS_W-1:0] nb_last;
  logic [NUM_BINS_W-1:0] clamped;
  logic [SUM_W-1:0]      inflight;

  // Hold off while clearing or while the queue could not take every item in flight
  assign inflight = SUM_W'(level) + SUM_W'(v1) + SUM_W'(v2);
  assign busy     = status.clearing || (inflight >= SUM_W'(QUEUE_DEPTH));
  assign accept   = start && !busy;

  // Classify the incoming item
  assign in_range = !((item.sample < left_edge) || (item.sample > right_edge));
  assign diff_in  = DATA_W'(item.sample - left_edge);
  assign hit_in   = (DATA_W'(item.bin_select) < DATA_W'(BINS));

  always_comb begin
    known = 1'b1;
    op_in = JOB_NONE;
    unique case (item.func)
      FUNC_CLEAR: op_in = JOB_CLEAR;
      FUNC_ADD:   op_in = in_range ? JOB_ADD : JOB_NONE;
      FUNC_READ:  op_in = JOB_READ;
      default:    known = 1'b0;
    endcase
  end

  // Configuration registers and stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      left_edge  <= LEFT_EDGE_RST;
      right_edge <= RIGHT_EDGE_RST;
      bin_scale  <= BIN_SCALE_RST;
      num_bins   <= NUM_BINS_RST;
      v1         <= 1'b0;
      v2         <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (reg_index_t'(cfg_index))
          REG_LEFT_EDGE:  left_edge  <= cfg_data;
          REG_RIGHT_EDGE: right_edge <= cfg_data;
          REG_BIN_SCALE:  bin_scale  <= cfg_data;
          REG_NUM_BINS:   num_bins   <= cfg_data[NUM_BINS_W-1:0];
        endcase
      end
      v1 <= accept && known;
      v2 <= v1;
    end
  end

  // Multiply the offset by the scale; keep the integer part
  assign prod = (2*DATA_W)'(diff1) * (2*DATA_W)'(bin_scale);

  // Pipeline payload
  always_ff @(posedge clk) begin
    op1   <= op_in;
    diff1 <= diff_in;
    sel1  <= item.bin_select;
    hit1  <= hit_in;
    op2   <= op1;
    hi2   <= prod[2*DATA_W-1:DATA_W];
    sel2  <= sel1;
    hit2  <= hit1;
  end

  // Last bin in use, with zero acting as one bin
  always_comb begin
    if (num_bins == '0) begin
      nb_last = '0;
    end else if (num_bins > NUM_BINS_W'(NB_MAX)) begin
      nb_last = LAST_MAX;
    end else begin
      nb_last = num_bins - NUM_BINS_W'(1);
    end
  end

  // Clamp to the last bin, covering a sample on the right edge
  assign clamped = (hi2 > DATA_W'(nb_last)) ? nb_last : hi2[NUM_BINS_W-1:0];

  assign push    = v2;
  assign job.op  = op2;
  assign job.bin = (op2 == JOB_ADD) ? clamped : NUM_BINS_W'(sel2);
  assign job.hit = hit2;

endmodule

### hdl/ubh_queue.sv
// Short job queue decoupling the front end from the back end.
// Depends on ubh_pkg.
module ubh_queue
  import ubh_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  job_t                job_in,
  input  logic                pop,
  output job_t                job_out,
  output logic                empty,
  output logic [QLEVEL_W-1:0] level
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;

  assign job_out = entries[head];
  assign empty   = (level == '0);

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        tail <= tail + QPTR_W'(1);
      end
      if (pop) begin
        head <= head + QPTR_W'(1);
      end
      level <= level + QLEVEL_W'(push) - QLEVEL_W'(pop);
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= job_in;
    end
  end

endmodule

### hdl/ubh_back.sv
// Back end: bin count memory, clearing sweep and read-modify-write of counts.
// Depends on ubh_pkg.
module ubh_back
  import ubh_pkg::*;
#(
  parameter int BINS        = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  job_t         job,
  input  logic         empty,
  output logic         pop,
  output back_status_t status,
  output logic         done,
  output result_t      result
);

  localparam int BIN_W = $clog2(BINS);
  localparam logic [BIN_W-1:0] LAST_ADDR = BIN_W'(BINS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS
  } state_t;

  state_t                 state;
  logic [BIN_W-1:0]       ptr;
  job_t                   cur;
  logic [COUNT_WIDTH-1:0] mem [BINS];
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [COUNT_WIDTH-1:0] inc;
  logic [BIN_W-1:0]       rd_addr;
  logic                   we;
  logic [BIN_W-1:0]       wa;
  logic [COUNT_WIDTH-1:0] wd;

  function automatic logic [BIN_W-1:0] to_addr(input logic [NUM_BINS_W-1:0] b);
    logic [BIN_W+NUM_BINS_W-1:0] w;
    w = {{BIN_W{1'b0}}, b};
    return w[BIN_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH+DATA_W-1:0] w;
    w = {{DATA_W{1'b0}}, c};
    return w[DATA_W-1:0];
  endfunction

  assign pop             = (state == ST_IDLE) && !empty;
  assign status.clearing = (state == ST_CLEAR);
  assign rd_addr         = to_addr(job.bin);

  // Saturating increment
  assign inc = (rd_data == '1) ? rd_data : rd_data + COUNT_WIDTH'(1);

  // Write port: sweep zeros or store the incremented count
  assign we = (state == ST_CLEAR) || ((state == ST_ACCESS) && (cur.op == JOB_ADD));
  assign wa = (state == ST_CLEAR) ? ptr : to_addr(cur.bin);
  assign wd = (state == ST_CLEAR) ? '0 : inc;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  // Sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      ptr   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          if (ptr == LAST_ADDR) begin
            ptr   <= '0;
            state <= ST_IDLE;
          end else begin
            ptr <= ptr + BIN_W'(1);
          end
        end
        ST_IDLE: begin
          if (!empty) begin
            cur <= job;
            unique case (job.op)
              JOB_CLEAR: begin
                done   <= 1'b1;
                result <= '0;
                state  <= ST_CLEAR;
              end
              JOB_NONE: begin
                done   <= 1'b1;
                result <= '0;
              end
              JOB_READ: begin
                if (job.hit) begin
                  state <= ST_ACCESS;
                end else begin
                  done              <= 1'b1;
                  result.bin_number <= job.bin[BIN_NUM_W-1:0];
                  result.bin_count  <= '0;
                  result.in_range   <= 1'b0;
                end
              end
              JOB_ADD: state <= ST_ACCESS;
            endcase
          end
        end
        ST_ACCESS: begin
          done              <= 1'b1;
          result.bin_number <= cur.bin[BIN_NUM_W-1:0];
          result.bin_count  <= (cur.op == JOB_ADD) ? to_out(inc) : to_out(rd_data);
          result.in_range   <= (cur.op == JOB_ADD);
          state             <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### hdl/uniform_bin_histogram.sv
// Uniform-bin histogram: clears, dropped samples and reads beyond the bins are
// answered from the back end's idle state; counted samples and reads take its
// access state. The count memory's read-modify-write sets throughput: an add or
// read holds the back end in its access state; a clear adds a sweep of all bins.
// Reset runs a clearing sweep of all bins with busy high; results carry no stall.
// Depends on ubh_pkg, ubh_front, ubh_queue and ubh_back.
module uniform_bin_histogram
  import ubh_pkg::*;
#(
  parameter int BINS        = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  item_t                  item,
  output logic                   done,
  output result_t                result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]      cfg_data
);

  logic                push;
  logic                pop;
  logic                empty;
  job_t                job_in;
  job_t                job_out;
  logic [QLEVEL_W-1:0] level;
  back_status_t        status;

  // Classify items and compute bins
  ubh_front #(
    .BINS (BINS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .level     (level),
    .status    (status),
    .push      (push),
    .job       (job_in)
  );

  // Buffer classified jobs
  ubh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .job_in  (job_in),
    .pop     (pop),
    .job_out (job_out),
    .empty   (empty),
    .level   (level)
  );

  // Update and read the counts
  ubh_back #(
    .BINS        (BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .job    (job_out),
    .empty  (empty),
    .pop    (pop),
    .status (status),
    .done   (done),
    .result (result)
  );

endmodule
